>>> rtl/i2a_pkg.sv
// Shared types, constants and the digit-to-character function of the integer to ASCII formatter.
// Used by i2a_digits and integer_to_ascii_formatter; depends on nothing.
package i2a_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int IN_WIDTH    = 64;
    localparam int NDIG        = 20;
    localparam int DIG_W       = 4 * NDIG;
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
    localparam int IDX_W       = $clog2(NDIG);

    localparam logic [2:0] KIND_SDEC  = 3'd0;
    localparam logic [2:0] KIND_UDEC  = 3'd1;
    localparam logic [2:0] KIND_HEXL  = 3'd2;
    localparam logic [2:0] KIND_HEXU  = 3'd3;
    localparam logic [2:0] KIND_HEX64 = 3'd4;

    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_LOW_A = 7'h61;
    localparam logic [6:0] CH_UP_A  = 7'h41;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CONV = 5'b00010,
        ST_SKIP = 5'b00100,
        ST_SIGN = 5'b01000,
        ST_EMIT = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;
        logic hex;
    } t_dig_ctrl;

    function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
        logic [6:0] base;
        base = upper ? CH_UP_A : CH_LOW_A;
        if (d < 4'd10) begin
            digit_char = CH_ZERO + {3'b000, d};
        end else begin
            digit_char = base + {3'b000, d} - 7'd10;
        end
    endfunction

endpackage

>>> rtl/i2a_digits.sv
// Digit store with a shared shift-and-add-3 unit: binary to BCD one bit per cycle,
// or a direct load of hex nibbles. Depends on i2a_pkg.
module i2a_digits (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  i2a_pkg::t_dig_ctrl                 i_ctrl,
    input  logic [i2a_pkg::VALUE_WIDTH-1:0]    i_bin,
    output logic [i2a_pkg::DIG_W-1:0]          o_digits,
    output logic                               o_done
);

    logic [i2a_pkg::VALUE_WIDTH-1:0] r_bin, n_bin;
    logic [i2a_pkg::DIG_W-1:0]       r_bcd, n_bcd;
    logic [i2a_pkg::DIG_W-1:0]       adj;
    logic [i2a_pkg::CNT_W-1:0]       r_cnt, n_cnt;

    always_comb begin
        for (int k = 0; k < i2a_pkg::NDIG; k++) begin
            if (r_bcd[4*k +: 4] >= 4'd5) begin
                adj[4*k +: 4] = r_bcd[4*k +: 4] + 4'd3;
            end else begin
                adj[4*k +: 4] = r_bcd[4*k +: 4];
            end
        end
    end

    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        n_cnt = r_cnt;
        if (i_ctrl.load) begin
            n_bin = i_bin;
            if (i_ctrl.hex) begin
                n_bcd = i2a_pkg::DIG_W'(i_bin);
                n_cnt = '0;
            end else begin
                n_bcd = '0;
                n_cnt = i2a_pkg::CNT_W'(i2a_pkg::VALUE_WIDTH);
            end
        end else if (r_cnt != '0) begin
            n_bcd = {adj[i2a_pkg::DIG_W-2:0], r_bin[i2a_pkg::VALUE_WIDTH-1]};
            n_bin = {r_bin[i2a_pkg::VALUE_WIDTH-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_digits = r_bcd;
    assign o_done   = (r_cnt == '0);

endmodule

>>> rtl/integer_to_ascii_formatter.sv
// Top level: integer to ASCII text, one character per result beat, leading zeros dropped.
// Depends on i2a_pkg and i2a_digits.
//
//  channel   handshake           payload
//  command   start / busy        i_value[63:0], i_req_type[2:0]
//  result    o_strobe (1 cycle)  o_ascii_char[6:0], o_last_char
//
// Decimal kinds hold the shift-and-add-3 unit at one bit a cycle through all VALUE_WIDTH bits, then
// the done check; hex kinds load their nibbles at the accepting edge. The scan takes one step
// per leading zero digit plus one, each character one step, and one more for a minus sign.
// Each beat shows in the cycle after its step; an unknown kind is taken without raising busy.
// Reset returns the sequencer to idle and drops the strobe. The receiver cannot stall.
module integer_to_ascii_formatter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [i2a_pkg::IN_WIDTH-1:0] i_value,
    input  logic [2:0]                    i_req_type,
    output logic                          o_strobe,
    output logic [6:0]                    o_ascii_char,
    output logic                          o_last_char
);

    i2a_pkg::t_state r_state, n_state;
    logic [i2a_pkg::IDX_W-1:0]       r_idx, n_idx;
    logic                            r_neg, n_neg;
    logic                            r_upper, n_upper;
    logic                            r_strobe, n_strobe;
    logic [6:0]                      r_char, n_char;
    logic                            r_last, n_last;

    logic                            accept;
    logic [i2a_pkg::VALUE_WIDTH-1:0] v;
    logic [i2a_pkg::VALUE_WIDTH-1:0] mag;
    logic                            kind_ok;
    logic                            kind_hex;
    logic                            kind_neg;
    logic                            kind_upper;
    i2a_pkg::t_dig_ctrl              dig_ctrl;
    logic [i2a_pkg::DIG_W-1:0]       digits;
    logic                            dig_done;
    logic [3:0]                      cur_dig;

    assign accept = start && !busy;
    assign v      = i_value[i2a_pkg::VALUE_WIDTH-1:0];

    always_comb begin
        kind_ok    = 1'b1;
        kind_hex   = 1'b0;
        kind_neg   = 1'b0;
        kind_upper = 1'b0;
        mag        = v;
        case (i_req_type)
            i2a_pkg::KIND_SDEC: begin
                kind_neg = v[i2a_pkg::VALUE_WIDTH-1];
                mag      = kind_neg ? (~v + 1'b1) : v;
            end
            i2a_pkg::KIND_UDEC: begin
                mag = i2a_pkg::VALUE_WIDTH'(v[31:0]);
            end
            i2a_pkg::KIND_HEXL: begin
                mag      = i2a_pkg::VALUE_WIDTH'(v[31:0]);
                kind_hex = 1'b1;
            end
            i2a_pkg::KIND_HEXU: begin
                mag        = i2a_pkg::VALUE_WIDTH'(v[31:0]);
                kind_hex   = 1'b1;
                kind_upper = 1'b1;
            end
            i2a_pkg::KIND_HEX64: begin
                kind_hex = 1'b1;
            end
            default: begin
                kind_ok = 1'b0;
            end
        endcase
    end

    assign dig_ctrl.load = accept && kind_ok;
    assign dig_ctrl.hex  = kind_hex;

    i2a_digits u_digits (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (dig_ctrl),
        .i_bin    (mag),
        .o_digits (digits),
        .o_done   (dig_done)
    );

    assign cur_dig = digits[r_idx*4 +: 4];

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_neg    = r_neg;
        n_upper  = r_upper;
        n_strobe = 1'b0;
        n_char   = r_char;
        n_last   = 1'b0;
        case (r_state)
            i2a_pkg::ST_IDLE: begin
                if (accept && kind_ok) begin
                    n_neg   = kind_neg;
                    n_upper = kind_upper;
                    n_idx   = i2a_pkg::IDX_W'(i2a_pkg::NDIG - 1);
                    n_state = kind_hex ? i2a_pkg::ST_SKIP : i2a_pkg::ST_CONV;
                end
            end
            i2a_pkg::ST_CONV: begin
                if (dig_done) begin
                    n_state = i2a_pkg::ST_SKIP;
                end
            end
            i2a_pkg::ST_SKIP: begin
                if (cur_dig == 4'd0 && r_idx != '0) begin
                    n_idx = r_idx - 1'b1;
                end else begin
                    n_state = r_neg ? i2a_pkg::ST_SIGN : i2a_pkg::ST_EMIT;
                end
            end
            i2a_pkg::ST_SIGN: begin
                n_strobe = 1'b1;
                n_char   = i2a_pkg::CH_MINUS;
                n_state  = i2a_pkg::ST_EMIT;
            end
            i2a_pkg::ST_EMIT: begin
                n_strobe = 1'b1;
                n_char   = i2a_pkg::digit_char(cur_dig, r_upper);
                n_last   = (r_idx == '0);
                if (r_idx == '0) begin
                    n_state = i2a_pkg::ST_IDLE;
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end
            default: begin
                n_state = i2a_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= i2a_pkg::ST_IDLE;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_last   <= n_last;
        end
        r_idx   <= n_idx;
        r_neg   <= n_neg;
        r_upper <= n_upper;
        r_char  <= n_char;
    end

    assign busy         = (r_state != i2a_pkg::ST_IDLE);
    assign o_strobe     = r_strobe;
    assign o_ascii_char = r_char;
    assign o_last_char  = r_last;

`ifndef SYNTHESIS
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(r_state) == i2a_pkg::ST_SIGN || $past(r_state) == i2a_pkg::ST_EMIT))
        else $error("strobe without a sign or digit step");
    a_last_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_char |-> o_strobe)
        else $error("last flag outside a beat");
    a_bad_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req_type > i2a_pkg::KIND_HEX64) |=> (r_state == i2a_pkg::ST_IDLE))
        else $error("unknown kind started a conversion");
    a_sign_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == i2a_pkg::ST_SIGN) |-> r_neg)
        else $error("sign step on a non-negative value");
    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == i2a_pkg::ST_SKIP || r_state == i2a_pkg::ST_EMIT) |-> dig_done)
        else $error("digits read before conversion finished");
`endif

endmodule
